// ===== hw/rtl/nps_pkg.sv =====
// ----------------------------------------------------------------------------
// nps_pkg
// Types and constants shared by the nearest point search block.
// ----------------------------------------------------------------------------
package nps_pkg;

  localparam int COORD_W    = 20;
  localparam int IDX_W      = 10;
  localparam int DIST_W     = 42;
  localparam int SUM_W      = 63;
  localparam int STATUS_W   = 3;
  localparam int REQ_TYPE_W = 2;
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 64;

  localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR = 2'd0;
  localparam logic [REQ_TYPE_W-1:0] REQ_LOAD  = 2'd1;
  localparam logic [REQ_TYPE_W-1:0] REQ_QUERY = 2'd2;
  localparam logic [REQ_TYPE_W-1:0] REQ_NONE  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_LOADED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FOUND   = 3'd4;

  localparam logic REG_TOLERANCE_SQ = 1'b0;

  typedef struct packed {
    logic [REQ_TYPE_W-1:0]     req_type;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    nearest_index;
    logic [DIST_W-1:0]   nearest_dist_sq;
    logic                within_tolerance;
    logic [SUM_W-1:0]    distance_sum;
  } rsp_t;

endpackage

// ===== hw/rtl/nearest_point_search.sv =====
// ----------------------------------------------------------------------------
// nearest_point_search
// Brute-force 3-D nearest point search over a store of reference points.
// ----------------------------------------------------------------------------
// Items clear the store, load one point, query with one point, or are ignored. A
// query reads the point store through its single read port, one point per
// cycle, and feeds a four-stage pipeline (read, difference, square, sum and
// compare). Items are taken one at a time, but a new item is accepted while
// the previous result still waits in the output register. The store needs no
// clearing pass after reset.
// ----------------------------------------------------------------------------
module nearest_point_search
  import nps_pkg::*;
#(
  parameter int MAX_POINTS = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  req_t                  req,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output rsp_t                  rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int AW     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW     = $clog2(MAX_POINTS + 1);
  localparam int PT_W   = 3 * COORD_W;
  localparam int DIFF_W = COORD_W + 1;
  localparam int SQ_W   = 2 * COORD_W + 1;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_RESULT = 2'd3;

  logic [1:0]          state;
  logic [CW-1:0]       count;
  logic [SUM_W-1:0]    running_sum;
  logic [DIST_W-1:0]   tolerance_sq;
  logic [STATUS_W-1:0] res_status;
  logic [PT_W-1:0]     query_pt;
  logic [CW-1:0]       issue_idx;
  logic [CW-1:0]       issue_idx_next;

  logic [PT_W-1:0]     mem [MAX_POINTS];
  logic [PT_W-1:0]     rd_data;
  logic                rd_en;
  logic                wr_en;

  logic                s1_valid;
  logic [AW-1:0]       s1_idx;
  logic                s2_valid;
  logic [AW-1:0]       s2_idx;
  logic [DIFF_W-1:0]   s2_abs [3];
  logic                s3_valid;
  logic [AW-1:0]       s3_idx;
  logic [SQ_W-1:0]     s3_sq [3];
  logic [DIST_W-1:0]   s3_sum;

  logic                best_valid;
  logic [AW-1:0]       best_idx;
  logic [DIST_W-1:0]   best_dist;

  logic                accept;
  logic                emit;
  logic                cfg_write;
  logic [SUM_W:0]      sum_ext;
  logic [SUM_W-1:0]    sum_sat;
  logic [IDX_W+AW-1:0] idx_ext;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[APB_ADDR_W-1:3] == REG_TOLERANCE_SQ)
                     ? {{(APB_DATA_W-DIST_W){1'b0}}, tolerance_sq} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance_sq <= '0;
    end else if (cfg_write && paddr[APB_ADDR_W-1:3] == REG_TOLERANCE_SQ) begin
      tolerance_sq <= pwdata[DIST_W-1:0];
    end
  end

  assign req_ready      = (state == S_IDLE);
  assign accept         = req_valid && req_ready;
  assign emit           = (state == S_RESULT) && (!rsp_valid || rsp_ready);
  assign issue_idx_next = issue_idx + 1'b1;
  assign rd_en          = (state == S_SCAN);
  assign wr_en          = accept && req.req_type == REQ_LOAD
                          && count != CW'(MAX_POINTS);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count[AW-1:0]] <= {req.coord_x, req.coord_y, req.coord_z};
    end
    if (rd_en) begin
      rd_data <= mem[issue_idx[AW-1:0]];
    end
  end

  always_comb begin
    s3_sum = DIST_W'(s3_sq[0]) + DIST_W'(s3_sq[1]) + DIST_W'(s3_sq[2]);
  end

  always_ff @(posedge clk) begin
    s1_idx <= issue_idx[AW-1:0];
    s2_idx <= s1_idx;
    s3_idx <= s2_idx;
    for (int k = 0; k < 3; k++) begin
      logic signed [DIFF_W-1:0] d;
      logic signed [COORD_W-1:0] a;
      logic signed [COORD_W-1:0] b;
      a = query_pt[PT_W-1-k*COORD_W -: COORD_W];
      b = rd_data[PT_W-1-k*COORD_W -: COORD_W];
      d = DIFF_W'(a) - DIFF_W'(b);
      s2_abs[k] <= d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
      s3_sq[k]  <= SQ_W'(s2_abs[k] * s2_abs[k]);
    end
    if (s3_valid && (!best_valid || s3_sum < best_dist)) begin
      best_dist <= s3_sum;
      best_idx  <= s3_idx;
    end
  end

  assign sum_ext = {1'b0, running_sum} + (SUM_W + 1)'(best_dist);
  assign sum_sat = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
  assign idx_ext = {{IDX_W{1'b0}}, best_idx};

  always_ff @(posedge clk) begin
    if (accept) begin
      query_pt <= {req.coord_x, req.coord_y, req.coord_z};
    end
    if (emit) begin
      rsp.status <= res_status;
      if (res_status == ST_FOUND) begin
        rsp.nearest_index    <= idx_ext[IDX_W-1:0];
        rsp.nearest_dist_sq  <= best_dist;
        rsp.within_tolerance <= (best_dist <= tolerance_sq);
        rsp.distance_sum     <= sum_sat;
      end else begin
        rsp.nearest_index    <= '0;
        rsp.nearest_dist_sq  <= '0;
        rsp.within_tolerance <= 1'b0;
        rsp.distance_sum     <= running_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      running_sum <= '0;
      res_status  <= ST_CLEARED;
      issue_idx   <= '0;
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      s3_valid    <= 1'b0;
      best_valid  <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      s1_valid <= rd_en;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      if (s3_valid) begin
        best_valid <= 1'b1;
      end
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (req.req_type)
              REQ_CLEAR: begin
                count       <= '0;
                running_sum <= '0;
                res_status  <= ST_CLEARED;
                state       <= S_RESULT;
              end
              REQ_LOAD: begin
                if (count != CW'(MAX_POINTS)) begin
                  count      <= count + 1'b1;
                  res_status <= ST_LOADED;
                end else begin
                  res_status <= ST_FULL;
                end
                state <= S_RESULT;
              end
              REQ_QUERY: begin
                best_valid <= 1'b0;
                issue_idx  <= '0;
                if (count == '0) begin
                  res_status <= ST_EMPTY;
                  state      <= S_RESULT;
                end else begin
                  res_status <= ST_FOUND;
                  state      <= S_SCAN;
                end
              end
              REQ_NONE: begin
                state <= S_IDLE;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_SCAN: begin
          issue_idx <= issue_idx_next;
          if (issue_idx_next == count) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!s1_valid && !s2_valid && !s3_valid) begin
            state <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (emit) begin
            if (res_status == ST_FOUND) begin
              running_sum <= sum_sat;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_POINTS))
    else $error("point count exceeds the store depth");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> issue_idx < count)
    else $error("scan reads beyond the loaded points");

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_FOUND |->
      rsp.nearest_dist_sq == '0 && !rsp.within_tolerance)
    else $error("result without a found point carries a distance");

  a_found_has_best: assert property (@(posedge clk) disable iff (rst)
    emit && res_status == ST_FOUND |-> best_valid)
    else $error("query result emitted before any point was compared");
`endif

endmodule

// ===== bench/tb_nearest_point_search.sv =====
// ----------------------------------------------------------------------------
// tb_nearest_point_search
// Self-checking bench for the brute-force 3-D nearest point search block.
// ----------------------------------------------------------------------------
// Requests go in over a valid/ready channel and each accepted item is fed to
// a scoreboard that mirrors the point store, the running distance sum and the
// tolerance register, and queues the answer the block must give. Answers are
// compared field by field in arrival order. A short directed opening covers
// coordinate extremes, ties, empty-store queries and ignored request codes.
// Random phases of clear/load/query sequences with noise follow under several
// tolerance settings and idle patterns, and a final phase loads a fresh batch
// of points and queries against it.
// ----------------------------------------------------------------------------
module tb_nearest_point_search;
  import nps_pkg::*;

  localparam int STORE_DEPTH = 1024;
  localparam int SETTLE_CYCLES = 16;
  localparam int QUIET_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 70;
  localparam int FINAL_LOADS = 32;
  localparam logic [APB_ADDR_W-1:0] TOL_ADDR = APB_ADDR_W'(REG_TOLERANCE_SQ) << 3;
  localparam logic [DIST_W-1:0] TOL_MAX = 42'd3298528591875;
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  class nearest_scoreboard;
    logic signed [COORD_W-1:0] px [STORE_DEPTH];
    logic signed [COORD_W-1:0] py [STORE_DEPTH];
    logic signed [COORD_W-1:0] pz [STORE_DEPTH];
    int unsigned stored;
    logic [SUM_W-1:0] total_sum = '0;
    logic [DIST_W-1:0] tolerance = '0;
    rsp_t awaited_rsp [$];
    int errors;
    int n_clear, n_load, n_full, n_query, n_empty, n_within, n_ignored;

    function void note_request(input req_t r);
      rsp_t want;
      longint dx, dy, dz, d, best;
      int unsigned i, best_idx;
      want = '0;
      case (r.req_type)
        REQ_NONE: begin
          n_ignored++;
          return;
        end
        REQ_CLEAR: begin
          stored = 0;
          total_sum = '0;
          want.status = ST_CLEARED;
          n_clear++;
        end
        REQ_LOAD: begin
          n_load++;
          if (stored < STORE_DEPTH) begin
            px[stored] = r.coord_x;
            py[stored] = r.coord_y;
            pz[stored] = r.coord_z;
            stored++;
            want.status = ST_LOADED;
          end else begin
            want.status = ST_FULL;
            n_full++;
          end
        end
        default: begin
          n_query++;
          if (stored == 0) begin
            want.status = ST_EMPTY;
            n_empty++;
          end else begin
            best = -1;
            best_idx = 0;
            for (i = 0; i < stored; i++) begin
              dx = longint'(r.coord_x) - longint'(px[i]);
              dy = longint'(r.coord_y) - longint'(py[i]);
              dz = longint'(r.coord_z) - longint'(pz[i]);
              d = dx * dx + dy * dy + dz * dz;
              if (best < 0 || d < best) begin
                best = d;
                best_idx = i;
              end
            end
            want.status = ST_FOUND;
            want.nearest_index = IDX_W'(best_idx);
            want.nearest_dist_sq = DIST_W'(best);
            want.within_tolerance = (want.nearest_dist_sq <= tolerance);
            if (want.within_tolerance) n_within++;
            if (total_sum > {SUM_W{1'b1}} - SUM_W'(want.nearest_dist_sq)) begin
              total_sum = {SUM_W{1'b1}};
            end else begin
              total_sum = total_sum + SUM_W'(want.nearest_dist_sq);
            end
          end
        end
      endcase
      want.distance_sum = total_sum;
      awaited_rsp.insert(awaited_rsp.size(), want);
    endfunction

    function void check_response(input rsp_t got);
      rsp_t want;
      if (awaited_rsp.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("Unexpected result: status %0d index %0d dist %0d within %0b sum %0d",
                   got.status, got.nearest_index, got.nearest_dist_sq,
                   got.within_tolerance, got.distance_sum);
        end
        return;
      end
      want = awaited_rsp.pop_front();
      if (got.status !== want.status || got.nearest_index !== want.nearest_index ||
          got.nearest_dist_sq !== want.nearest_dist_sq ||
          got.within_tolerance !== want.within_tolerance ||
          got.distance_sum !== want.distance_sum) begin
        errors++;
        if (errors <= 10) begin
          $display("Mismatch (expected/actual): status %0d/%0d index %0d/%0d dist %0d/%0d",
                   want.status, got.status, want.nearest_index, got.nearest_index,
                   want.nearest_dist_sq, got.nearest_dist_sq);
          $display("  within %0b/%0b sum %0d/%0d", want.within_tolerance,
                   got.within_tolerance, want.distance_sum, got.distance_sum);
        end
      end
    endfunction

    function int failures();
      return errors + awaited_rsp.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  nearest_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_len = 0;
  int quiet_cycles = 0;
  int tol_writes = 0;

  nearest_point_search #(
    .MAX_POINTS(STORE_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    if (hold_len > 0) begin
      hold_len <= hold_len - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid === 1'b1 && rsp_ready) sb.check_response(rsp);
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[nearest_point_search] ERROR");
      $finish;
    end
  end

  function automatic req_t make_request(input logic [REQ_TYPE_W-1:0] kind,
                                        input logic signed [COORD_W-1:0] x,
                                        input logic signed [COORD_W-1:0] y,
                                        input logic signed [COORD_W-1:0] z);
    req_t r;
    r.req_type = kind;
    r.coord_x = x;
    r.coord_y = y;
    r.coord_z = z;
    return r;
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(7))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return COORD_W'($urandom_range(2)) - COORD_W'(1);
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [COORD_W-1:0] nudge(input logic signed [COORD_W-1:0] c,
                                                      input int span);
    return c + COORD_W'($urandom_range(2 * span)) - COORD_W'(span);
  endfunction

  // Most queries land on or near a stored point so that small distances,
  // exact hits and the tolerance boundary all come up often.
  function automatic req_t query_point();
    int unsigned k;
    int span;
    if (sb.stored == 0 || $urandom_range(99) < 35) begin
      return make_request(REQ_QUERY, rand_coord(), rand_coord(), rand_coord());
    end
    k = $urandom_range(sb.stored - 1);
    span = ($urandom_range(3) == 0) ? 0 : (1 << $urandom_range(10));
    return make_request(REQ_QUERY, nudge(sb.px[k], span), nudge(sb.py[k], span),
                        nudge(sb.pz[k], span));
  endfunction

  task automatic send_request(input req_t r);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_ready !== 1'b1);
    sb.note_request(r);
  endtask

  task automatic rest_and_drain();
    @(negedge clk);
    req_valid <= 1'b0;
    while (sb.awaited_rsp.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_tolerance(input logic [DIST_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= TOL_ADDR;
    pwdata <= APB_DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.tolerance = value;
    tol_writes++;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic run_random(input int count, input bit stall_receiver);
    int sent, nload, nquery;
    sent = 0;
    while (sent < count) begin
      if (stall_receiver && sent >= count / 3) begin
        hold_len = 400;
        stall_receiver = 1'b0;
      end
      if ($urandom_range(99) < 80) begin
        if (sb.stored > 80 || $urandom_range(3) != 0) begin
          send_request(make_request(REQ_CLEAR, rand_coord(), rand_coord(), rand_coord()));
          sent++;
        end
        nload = ($urandom_range(9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 8);
        repeat (nload) begin
          send_request(make_request(REQ_LOAD, rand_coord(), rand_coord(), rand_coord()));
          sent++;
        end
        nquery = $urandom_range(1, 6);
        repeat (nquery) begin
          send_request(query_point());
          sent++;
        end
      end else begin
        case ($urandom_range(3))
          0: send_request(make_request(REQ_NONE, rand_coord(), rand_coord(), rand_coord()));
          1: begin
            send_request(make_request(REQ_CLEAR, rand_coord(), rand_coord(), rand_coord()));
            send_request(query_point());
            sent += 2;
          end
          2: begin
            send_request(make_request(REQ_LOAD, rand_coord(), rand_coord(), rand_coord()));
            sent++;
          end
          default: begin
            send_request(query_point());
            sent++;
          end
        endcase
      end
    end
  endtask

  initial begin
    logic [DIST_W-1:0] tol_plan [6];
    int mode, sub;
    tol_plan[0] = TOL_MAX;
    tol_plan[1] = DIST_W'($urandom_range(1 << 22));
    tol_plan[2] = '0;
    tol_plan[3] = DIST_W'({$urandom, $urandom} % (64'(TOL_MAX) + 64'd1));
    tol_plan[4] = DIST_W'(1 << 21);
    tol_plan[5] = TOL_MAX;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_tolerance('0);
    send_request(make_request(REQ_QUERY, '0, '0, '0));
    send_request(make_request(REQ_LOAD, COORD_MIN, COORD_MIN, COORD_MIN));
    send_request(make_request(REQ_QUERY, COORD_MAX, COORD_MAX, COORD_MAX));
    send_request(make_request(REQ_LOAD, COORD_MAX, COORD_MAX, COORD_MAX));
    send_request(make_request(REQ_LOAD, '0, '0, '0));
    send_request(make_request(REQ_LOAD, '0, '0, '0));
    send_request(make_request(REQ_QUERY, '0, '0, '0));
    send_request(make_request(REQ_QUERY, 20'sd1, '0, -20'sd1));
    send_request(make_request(REQ_LOAD, COORD_MAX, COORD_MIN, COORD_MAX));
    send_request(make_request(REQ_QUERY, COORD_MAX, COORD_MIN, COORD_MIN));
    send_request(make_request(REQ_NONE, COORD_MAX, COORD_MIN, COORD_MAX));
    send_request(make_request(REQ_QUERY, -20'sd1, -20'sd1, -20'sd1));
    // Equidistant from the origin and from the point below: lower index wins.
    send_request(make_request(REQ_LOAD, -20'sd2, '0, '0));
    send_request(make_request(REQ_QUERY, -20'sd1, '0, '0));
    send_request(make_request(REQ_QUERY, COORD_MIN, COORD_MAX, COORD_MIN));
    send_request(make_request(REQ_CLEAR, COORD_MAX, COORD_MAX, COORD_MAX));
    send_request(make_request(REQ_QUERY, COORD_MAX, '0, COORD_MIN));
    send_request(make_request(REQ_NONE, '0, '0, '0));
    send_request(make_request(REQ_LOAD, 20'sh5A5A5, 20'shA5A5A, 20'sh0F0F0));
    send_request(make_request(REQ_QUERY, 20'sh5A5A5, 20'shA5A5A, 20'sh0F0F0));
    rest_and_drain();

    for (mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 34 : (mode == 1) ? 52 : 0;
      recv_idle_pct = (mode == 0) ? 52 : (mode == 1) ? 34 : 0;
      for (sub = 0; sub < 2; sub++) begin
        write_tolerance(tol_plan[2 * mode + sub]);
        run_random(RANDOM_ITEMS, mode == 0 && sub == 0);
        rest_and_drain();
      end
    end

    write_tolerance(DIST_W'(1 << 20));
    send_request(make_request(REQ_CLEAR, '0, '0, '0));
    repeat (FINAL_LOADS) begin
      send_request(make_request(REQ_LOAD, rand_coord(), rand_coord(), rand_coord()));
    end
    send_request(make_request(REQ_QUERY, sb.px[sb.stored-1], sb.py[sb.stored-1],
                              sb.pz[sb.stored-1]));
    repeat (3) send_request(query_point());
    send_request(make_request(REQ_CLEAR, '0, '0, '0));
    send_request(query_point());
    rest_and_drain();

    $display("Covered %0d clears, %0d loads (%0d dropped on a full store), %0d queries",
             sb.n_clear, sb.n_load, sb.n_full, sb.n_query);
    $display("(%0d on an empty store, %0d within tolerance), %0d ignored items, %0d tolerances.",
             sb.n_empty, sb.n_within, sb.n_ignored, tol_writes);
    if (sb.failures() == 0) begin
      $display("[nearest_point_search] OK");
    end else begin
      $display("[nearest_point_search] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/nps_pkg.sv
hw/rtl/nearest_point_search.sv
bench/tb_nearest_point_search.sv
